// ===== hw/rtl/cgda_pkg.sv =====
package cgda_pkg;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALPHA_RE  = 2'd0,
        REG_ALPHA_IM  = 2'd1,
        REG_CONJ_MODE = 2'd2
    } t_cfg_reg;

    localparam int CONJ_W     = 2;
    localparam int CONJ_B_BIT = 0;
    localparam int CONJ_A_BIT = 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam int STEP_W      = 3;
    localparam int TERM_STEPS  = 4;
    localparam int FINAL_STEPS = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM,
        ST_TDRAIN,
        ST_FINAL,
        ST_FDRAIN,
        ST_ROUND
    } t_state;

    typedef enum logic [1:0] {
        DST_ACC_RE,
        DST_ACC_IM,
        DST_FIN_RE,
        DST_FIN_IM
    } t_prod_dst;

    typedef struct packed {
        logic      valid;
        t_prod_dst dst;
        logic      neg;
        logic      hi;
    } t_prod_op;

endpackage

// ===== hw/rtl/cgda_front.sv =====
module cgda_front #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic signed [DATA_WIDTH-1:0]   i_a_re,
    input  logic signed [DATA_WIDTH-1:0]   i_a_im,
    input  logic signed [DATA_WIDTH-1:0]   i_b_re,
    input  logic signed [DATA_WIDTH-1:0]   i_b_im,
    input  logic signed [DATA_WIDTH-1:0]   i_c_re,
    input  logic signed [DATA_WIDTH-1:0]   i_c_im,
    input  logic                           i_last,
    input  logic [cgda_pkg::CONJ_W-1:0]    i_conj_mode,
    output logic                           o_q_valid,
    input  logic                           i_q_pop,
    output logic signed [DATA_WIDTH:0]     o_q_ar,
    output logic signed [DATA_WIDTH:0]     o_q_ai,
    output logic signed [DATA_WIDTH:0]     o_q_br,
    output logic signed [DATA_WIDTH:0]     o_q_bi,
    output logic signed [DATA_WIDTH-1:0]   o_q_cre,
    output logic signed [DATA_WIDTH-1:0]   o_q_cim,
    output logic                           o_q_last
);

    logic signed [DATA_WIDTH:0]   r_ar   [cgda_pkg::QUEUE_DEPTH];
    logic signed [DATA_WIDTH:0]   r_ai   [cgda_pkg::QUEUE_DEPTH];
    logic signed [DATA_WIDTH:0]   r_br   [cgda_pkg::QUEUE_DEPTH];
    logic signed [DATA_WIDTH:0]   r_bi   [cgda_pkg::QUEUE_DEPTH];
    logic signed [DATA_WIDTH-1:0] r_cre  [cgda_pkg::QUEUE_DEPTH];
    logic signed [DATA_WIDTH-1:0] r_cim  [cgda_pkg::QUEUE_DEPTH];
    logic                         r_last [cgda_pkg::QUEUE_DEPTH];

    logic [cgda_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [cgda_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [cgda_pkg::QCNT_W-1:0] r_count, n_count;

    logic                       wr_en;
    logic                       rd_en;
    logic signed [DATA_WIDTH:0] a_im_x;
    logic signed [DATA_WIDTH:0] b_im_x;

    assign o_full    = (r_count == cgda_pkg::QCNT_W'(cgda_pkg::QUEUE_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign wr_en     = i_push && !o_full;
    assign rd_en     = i_q_pop && o_q_valid;

    // The conjugate negation is made one bit wider so that negating the most
    // negative value stays exact.
    always_comb begin
        a_im_x = (DATA_WIDTH + 1)'(i_a_im);
        b_im_x = (DATA_WIDTH + 1)'(i_b_im);
        if (i_conj_mode[cgda_pkg::CONJ_A_BIT]) begin
            a_im_x = -a_im_x;
        end
        if (i_conj_mode[cgda_pkg::CONJ_B_BIT]) begin
            b_im_x = -b_im_x;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ar[r_wr_ptr]   <= (DATA_WIDTH + 1)'(i_a_re);
            r_ai[r_wr_ptr]   <= a_im_x;
            r_br[r_wr_ptr]   <= (DATA_WIDTH + 1)'(i_b_re);
            r_bi[r_wr_ptr]   <= b_im_x;
            r_cre[r_wr_ptr]  <= i_c_re;
            r_cim[r_wr_ptr]  <= i_c_im;
            r_last[r_wr_ptr] <= i_last;
        end
    end

    assign o_q_ar   = r_ar[r_rd_ptr];
    assign o_q_ai   = r_ai[r_rd_ptr];
    assign o_q_br   = r_br[r_rd_ptr];
    assign o_q_bi   = r_bi[r_rd_ptr];
    assign o_q_cre  = r_cre[r_rd_ptr];
    assign o_q_cim  = r_cim[r_rd_ptr];
    assign o_q_last = r_last[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cgda_pkg::QCNT_W'(cgda_pkg::QUEUE_DEPTH))
        else $error("front queue count exceeds its depth");

endmodule

// ===== hw/rtl/cgda_back.sv =====
module cgda_back #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic signed [DATA_WIDTH-1:0]   i_alpha_re,
    input  logic signed [DATA_WIDTH-1:0]   i_alpha_im,
    input  logic                           i_q_valid,
    output logic                           o_q_pop,
    input  logic signed [DATA_WIDTH:0]     i_q_ar,
    input  logic signed [DATA_WIDTH:0]     i_q_ai,
    input  logic signed [DATA_WIDTH:0]     i_q_br,
    input  logic signed [DATA_WIDTH:0]     i_q_bi,
    input  logic signed [DATA_WIDTH-1:0]   i_q_cre,
    input  logic signed [DATA_WIDTH-1:0]   i_q_cim,
    input  logic                           i_q_last,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic signed [DATA_WIDTH-1:0]   o_out_re,
    output logic signed [DATA_WIDTH-1:0]   o_out_im,
    output logic                           o_saturated
);

    localparam int LO_W  = ACC_WIDTH / 2;
    localparam int MA_W  = (DATA_WIDTH > LO_W) ? DATA_WIDTH + 1 : LO_W + 1;
    localparam int MB_W  = DATA_WIDTH + 1;
    localparam int PW    = MA_W + MB_W;
    localparam int SHIFT = 2 * DATA_WIDTH - 2;
    localparam int FW    = ((ACC_WIDTH + DATA_WIDTH > 3 * DATA_WIDTH - 2) ?
                            ACC_WIDTH + DATA_WIDTH : 3 * DATA_WIDTH - 2) + 2;
    localparam logic [FW-1:0] HALF = {{(FW - SHIFT){1'b0}}, 1'b1, {(SHIFT - 1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] OUT_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    cgda_pkg::t_state               r_state, n_state;
    logic [cgda_pkg::STEP_W-1:0]    r_step, n_step;
    cgda_pkg::t_prod_op             r_op, issue_op;

    logic signed [DATA_WIDTH:0]     r_ar, r_ai, r_br, r_bi;
    logic                           r_last;
    logic signed [ACC_WIDTH-1:0]    r_acc_re, n_acc_re;
    logic signed [ACC_WIDTH-1:0]    r_acc_im, n_acc_im;
    logic signed [FW-1:0]           r_fin_re, n_fin_re;
    logic signed [FW-1:0]           r_fin_im, n_fin_im;
    logic signed [PW-1:0]           r_prod;

    logic                           r_out_full;
    logic signed [DATA_WIDTH-1:0]   r_out_re, r_out_im;
    logic                           r_out_sat;

    logic signed [MA_W-1:0]         mul_a;
    logic signed [MB_W-1:0]         mul_b;
    logic                           item_load;
    logic                           acc_clear;
    logic                           out_load;
    logic                           out_free;

    logic signed [MA_W-1:0]         are_hi, are_lo, aim_hi, aim_lo;
    logic signed [MB_W-1:0]         alr, ali;
    logic signed [ACC_WIDTH-1:0]    prod_acc;
    logic signed [FW-1:0]           prod_fin;
    logic signed [FW-1:0]           sum_re, sum_im;
    logic [DATA_WIDTH-1:0]          rnd_re, rnd_im;
    logic                           clip_re, clip_im;

    assign out_free = !r_out_full || i_pop;

    assign are_hi = MA_W'(signed'(r_acc_re[ACC_WIDTH-1:LO_W]));
    assign aim_hi = MA_W'(signed'(r_acc_im[ACC_WIDTH-1:LO_W]));
    assign are_lo = MA_W'(signed'({1'b0, r_acc_re[LO_W-1:0]}));
    assign aim_lo = MA_W'(signed'({1'b0, r_acc_im[LO_W-1:0]}));
    assign alr    = MB_W'(i_alpha_re);
    assign ali    = MB_W'(i_alpha_im);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            cgda_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = cgda_pkg::ST_TERM;
                    n_step  = '0;
                end
            end
            cgda_pkg::ST_TERM: begin
                if (r_step == cgda_pkg::STEP_W'(cgda_pkg::TERM_STEPS - 1)) begin
                    n_state = cgda_pkg::ST_TDRAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            cgda_pkg::ST_TDRAIN: begin
                n_step = '0;
                if (r_last) begin
                    n_state = cgda_pkg::ST_FINAL;
                end else begin
                    n_state = cgda_pkg::ST_IDLE;
                end
            end
            cgda_pkg::ST_FINAL: begin
                if (r_step == cgda_pkg::STEP_W'(cgda_pkg::FINAL_STEPS - 1)) begin
                    n_state = cgda_pkg::ST_FDRAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            cgda_pkg::ST_FDRAIN: begin
                n_state = cgda_pkg::ST_ROUND;
            end
            cgda_pkg::ST_ROUND: begin
                if (out_free) begin
                    n_state = cgda_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cgda_pkg::ST_IDLE;
            end
        endcase
    end

    // Each step issues one partial product; it is added in the next cycle.
    always_comb begin
        item_load = 1'b0;
        acc_clear = 1'b0;
        out_load  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        issue_op  = '{valid: 1'b0, dst: cgda_pkg::DST_ACC_RE, neg: 1'b0, hi: 1'b0};
        case (r_state)
            cgda_pkg::ST_IDLE: begin
                item_load = i_q_valid;
            end
            cgda_pkg::ST_TERM: begin
                issue_op.valid = 1'b1;
                case (r_step)
                    3'd0: begin
                        mul_a = MA_W'(r_ar);
                        mul_b = r_br;
                    end
                    3'd1: begin
                        mul_a        = MA_W'(r_ai);
                        mul_b        = r_bi;
                        issue_op.neg = 1'b1;
                    end
                    3'd2: begin
                        mul_a        = MA_W'(r_ai);
                        mul_b        = r_br;
                        issue_op.dst = cgda_pkg::DST_ACC_IM;
                    end
                    default: begin
                        mul_a        = MA_W'(r_ar);
                        mul_b        = r_bi;
                        issue_op.dst = cgda_pkg::DST_ACC_IM;
                    end
                endcase
            end
            cgda_pkg::ST_FINAL: begin
                issue_op.valid = 1'b1;
                issue_op.hi    = !r_step[0];
                acc_clear = (r_step == cgda_pkg::STEP_W'(cgda_pkg::FINAL_STEPS - 1));
                case (r_step)
                    3'd0: begin
                        mul_a        = are_hi;
                        mul_b        = alr;
                        issue_op.dst = cgda_pkg::DST_FIN_RE;
                    end
                    3'd1: begin
                        mul_a        = are_lo;
                        mul_b        = alr;
                        issue_op.dst = cgda_pkg::DST_FIN_RE;
                    end
                    3'd2: begin
                        mul_a        = aim_hi;
                        mul_b        = ali;
                        issue_op.dst = cgda_pkg::DST_FIN_RE;
                        issue_op.neg = 1'b1;
                    end
                    3'd3: begin
                        mul_a        = aim_lo;
                        mul_b        = ali;
                        issue_op.dst = cgda_pkg::DST_FIN_RE;
                        issue_op.neg = 1'b1;
                    end
                    3'd4: begin
                        mul_a        = aim_hi;
                        mul_b        = alr;
                        issue_op.dst = cgda_pkg::DST_FIN_IM;
                    end
                    3'd5: begin
                        mul_a        = aim_lo;
                        mul_b        = alr;
                        issue_op.dst = cgda_pkg::DST_FIN_IM;
                    end
                    3'd6: begin
                        mul_a        = are_hi;
                        mul_b        = ali;
                        issue_op.dst = cgda_pkg::DST_FIN_IM;
                    end
                    default: begin
                        mul_a        = are_lo;
                        mul_b        = ali;
                        issue_op.dst = cgda_pkg::DST_FIN_IM;
                    end
                endcase
            end
            cgda_pkg::ST_ROUND: begin
                out_load = out_free;
            end
            default: begin
                item_load = 1'b0;
            end
        endcase
    end

    assign o_q_pop = item_load;

    always_comb begin
        prod_acc = ACC_WIDTH'(r_prod);
        prod_fin = FW'(r_prod);
        if (r_op.hi) begin
            prod_fin = prod_fin <<< LO_W;
        end
        n_acc_re = r_acc_re;
        n_acc_im = r_acc_im;
        n_fin_re = r_fin_re;
        n_fin_im = r_fin_im;
        if (item_load) begin
            n_fin_re = FW'(i_q_cre) <<< SHIFT;
            n_fin_im = FW'(i_q_cim) <<< SHIFT;
        end
        if (r_op.valid) begin
            case (r_op.dst)
                cgda_pkg::DST_ACC_RE: begin
                    n_acc_re = r_op.neg ? r_acc_re - prod_acc : r_acc_re + prod_acc;
                end
                cgda_pkg::DST_ACC_IM: begin
                    n_acc_im = r_op.neg ? r_acc_im - prod_acc : r_acc_im + prod_acc;
                end
                cgda_pkg::DST_FIN_RE: begin
                    n_fin_re = r_op.neg ? r_fin_re - prod_fin : r_fin_re + prod_fin;
                end
                default: begin
                    n_fin_im = r_op.neg ? r_fin_im - prod_fin : r_fin_im + prod_fin;
                end
            endcase
        end
        if (acc_clear) begin
            n_acc_re = '0;
            n_acc_im = '0;
        end
    end

    always_comb begin
        sum_re  = r_fin_re + signed'(HALF);
        sum_im  = r_fin_im + signed'(HALF);
        clip_re = !(&sum_re[FW-1:SHIFT+DATA_WIDTH-1] || !(|sum_re[FW-1:SHIFT+DATA_WIDTH-1]));
        clip_im = !(&sum_im[FW-1:SHIFT+DATA_WIDTH-1] || !(|sum_im[FW-1:SHIFT+DATA_WIDTH-1]));
        rnd_re  = sum_re[SHIFT+DATA_WIDTH-1:SHIFT];
        rnd_im  = sum_im[SHIFT+DATA_WIDTH-1:SHIFT];
        if (clip_re) begin
            rnd_re = sum_re[FW-1] ? OUT_MIN : OUT_MAX;
        end
        if (clip_im) begin
            rnd_im = sum_im[FW-1] ? OUT_MIN : OUT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cgda_pkg::ST_IDLE;
            r_step     <= '0;
            r_op       <= '{valid: 1'b0, dst: cgda_pkg::DST_ACC_RE, neg: 1'b0, hi: 1'b0};
            r_acc_re   <= '0;
            r_acc_im   <= '0;
            r_out_full <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_op     <= issue_op;
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
            if (out_load) begin
                r_out_full <= 1'b1;
            end else if (i_pop) begin
                r_out_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= mul_a * mul_b;
        r_fin_re <= n_fin_re;
        r_fin_im <= n_fin_im;
        if (item_load) begin
            r_ar   <= i_q_ar;
            r_ai   <= i_q_ai;
            r_br   <= i_q_br;
            r_bi   <= i_q_bi;
            r_last <= i_q_last;
        end
        if (out_load) begin
            r_out_re  <= signed'(rnd_re);
            r_out_im  <= signed'(rnd_im);
            r_out_sat <= clip_re || clip_im;
        end
    end

    assign o_empty     = !r_out_full;
    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;
    assign o_saturated = r_out_sat;

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cgda_pkg::ST_FDRAIN) |-> (r_acc_re == '0 && r_acc_im == '0))
        else $error("accumulator not cleared after the final sum");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("front queue popped while empty");

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_full || i_pop))
        else $error("result slot overwritten");

    a_term_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cgda_pkg::ST_TDRAIN) |->
        (r_op.valid && r_op.dst == cgda_pkg::DST_ACC_IM))
        else $error("term drain without its last partial product");

    a_final_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cgda_pkg::ST_FINAL && r_step == '0) |-> !r_op.valid)
        else $error("final sum started before the accumulator settled");

endmodule

// ===== hw/rtl/complex_gemm_dot_accumulate.sv =====
// Complex dot-product accumulator: each beat pushed in adds the product a*b
// (with a, b or both conjugated per conj_mode) into a complex accumulator of
// ACC_WIDTH bits per part, which wraps on overflow. A beat with last set also
// produces one result, c + alpha*acc rounded half up to Q(DATA_WIDTH-1) and
// saturated, and clears the accumulator. Beats land in a two-entry queue and
// are worked off by one shared multiplier, one partial product per cycle: a
// beat without last passes a load step, four term products and a drain
// step; a beat with last goes on with eight alpha products over the
// accumulator halves, a drain and a rounding step. The result waits in an
// output register until popped while further beats are taken; the rounding
// step is held for as long as that register still holds an earlier result.
// Configuration writes must only be issued while the block is idle.
module complex_gemm_dot_accumulate #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [DATA_WIDTH-1:0]       i_a_re,
    input  logic signed [DATA_WIDTH-1:0]       i_a_im,
    input  logic signed [DATA_WIDTH-1:0]       i_b_re,
    input  logic signed [DATA_WIDTH-1:0]       i_b_im,
    input  logic signed [DATA_WIDTH-1:0]       i_c_re,
    input  logic signed [DATA_WIDTH-1:0]       i_c_im,
    input  logic                               i_last,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [DATA_WIDTH-1:0]       o_out_re,
    output logic signed [DATA_WIDTH-1:0]       o_out_im,
    output logic                               o_saturated,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cgda_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [DATA_WIDTH-1:0]              i_cfg_data
);

    localparam logic [DATA_WIDTH-1:0] ALPHA_RE_RESET = {1'b0, {(DATA_WIDTH - 1){1'b1}}};

    logic signed [DATA_WIDTH-1:0]      r_alpha_re;
    logic signed [DATA_WIDTH-1:0]      r_alpha_im;
    logic [cgda_pkg::CONJ_W-1:0]       r_conj_mode;

    logic                              q_valid;
    logic                              q_pop;
    logic signed [DATA_WIDTH:0]        q_ar, q_ai, q_br, q_bi;
    logic signed [DATA_WIDTH-1:0]      q_cre, q_cim;
    logic                              q_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_re  <= signed'(ALPHA_RE_RESET);
            r_alpha_im  <= '0;
            r_conj_mode <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cgda_pkg::REG_ALPHA_RE:  r_alpha_re  <= signed'(i_cfg_data);
                cgda_pkg::REG_ALPHA_IM:  r_alpha_im  <= signed'(i_cfg_data);
                cgda_pkg::REG_CONJ_MODE: r_conj_mode <= i_cfg_data[cgda_pkg::CONJ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cgda_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_a_re      (i_a_re),
        .i_a_im      (i_a_im),
        .i_b_re      (i_b_re),
        .i_b_im      (i_b_im),
        .i_c_re      (i_c_re),
        .i_c_im      (i_c_im),
        .i_last      (i_last),
        .i_conj_mode (r_conj_mode),
        .o_q_valid   (q_valid),
        .i_q_pop     (q_pop),
        .o_q_ar      (q_ar),
        .o_q_ai      (q_ai),
        .o_q_br      (q_br),
        .o_q_bi      (q_bi),
        .o_q_cre     (q_cre),
        .o_q_cim     (q_cim),
        .o_q_last    (q_last)
    );

    cgda_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_alpha_re  (r_alpha_re),
        .i_alpha_im  (r_alpha_im),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_ar      (q_ar),
        .i_q_ai      (q_ai),
        .i_q_br      (q_br),
        .i_q_bi      (q_bi),
        .i_q_cre     (q_cre),
        .i_q_cim     (q_cim),
        .i_q_last    (q_last),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_re    (o_out_re),
        .o_out_im    (o_out_im),
        .o_saturated (o_saturated)
    );

endmodule
